// ----- hw/rtl/fdp_pkg.sv -----
`timescale 1ns / 1ps

package fdp_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int FP_W   = 32;
  localparam int LEN_W  = 16;

  // The longest vector is 65535 elements, which the 16-bit length field
  // can never exceed, so no saturation logic is needed.
  localparam logic [LEN_W-1:0] MAX_LENGTH = 16'hFFFF;

  localparam logic [FP_W-1:0] FP_POS_ZERO     = 32'h0000_0000;
  localparam logic [FP_W-1:0] FP_QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [FP_W-1:0] FP_QUIET_BIT    = 32'h0040_0000;

  // Per-item control, worked out when the item is accepted.
  typedef struct packed {
    logic              zero_k;     // first element of the vector
    logic              in_full;    // element belongs to a full group of eight
    logic              first_grp;  // element belongs to the first group
    logic              last_full;  // last element of the full groups
    logic              last;       // last element of the vector
    logic [LANE_W-1:0] lane;
  } item_ctl_t;

  typedef enum logic [1:0] {
    RED_IDLE,
    RED_PAIR,
    RED_QUAD,
    RED_FINAL
  } red_state_t;

endpackage

// ----- hw/rtl/fdp_in_if.sv -----
`timescale 1ns / 1ps

interface fdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_value;
  logic [31:0] b_value;
  logic [15:0] vector_length;

  modport source(output valid, output a_value, output b_value, output vector_length,
                 input ready);
  modport sink(input valid, input a_value, input b_value, input vector_length,
               output ready);
endinterface

// ----- hw/rtl/fdp_out_if.sv -----
`timescale 1ns / 1ps

interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_value;

  modport source(output valid, output dot_value, input ready);
  modport sink(input valid, input dot_value, output ready);
endinterface

// ----- hw/rtl/fdp_fmul.sv -----
`timescale 1ns / 1ps

module fdp_fmul import fdp_pkg::*; (
  input  logic [FP_W-1:0] x,
  input  logic [FP_W-1:0] y,
  output logic [FP_W-1:0] prod
);

  logic               x_nan, y_nan, x_inf, y_inf, x_zero, y_zero, sgn;
  logic [7:0]         ex, ey, ef;
  logic [23:0]        mx, my, mant;
  logic [47:0]        p, q, qs, lost_mask;
  logic [5:0]         lz, r_c;
  logic signed [11:0] e, en, r;
  logic               g, st, inc;
  logic [30:0]        mag;

  always_comb begin
    x_nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    y_nan  = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    x_inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    y_inf  = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    x_zero = (x[30:0] == 31'd0);
    y_zero = (y[30:0] == 31'd0);
    sgn    = x[31] ^ y[31];

    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {y[30:23] != 8'd0, y[22:0]};
    p  = mx * my;

    lz = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    q = p << lz;

    e  = $signed({4'd0, ex}) + $signed({4'd0, ey}) - 12'sd127;
    en = e + 12'sd1 - $signed({6'd0, lz});
    r  = 12'sd1 - en;
    r_c = (r > 12'sd48) ? 6'd48 : r[5:0];

    qs        = q;
    lost_mask = 48'd0;
    ef        = en[7:0];
    if (en < 12'sd1) begin
      // Result is subnormal: shift right, keeping the lost bits as sticky.
      qs        = q >> r_c;
      lost_mask = (48'd1 << r_c) - 48'd1;
      ef        = 8'd0;
    end
    mant = qs[47:24];
    g    = qs[23];
    st   = (|qs[22:0]) | (|(q & lost_mask));
    inc  = g & (st | mant[0]);
    mag  = {ef, mant[22:0]} + {30'd0, inc};

    if (x_nan) begin
      prod = x | FP_QUIET_BIT;
    end else if (y_nan) begin
      prod = y | FP_QUIET_BIT;
    end else if ((x_inf && y_zero) || (y_inf && x_zero)) begin
      prod = FP_QNAN_DEFAULT;
    end else if (x_inf || y_inf) begin
      prod = {sgn, 8'hFF, 23'd0};
    end else if (x_zero || y_zero) begin
      prod = {sgn, 31'd0};
    end else if (en >= 12'sd255) begin
      prod = {sgn, 8'hFF, 23'd0};
    end else begin
      prod = {sgn, mag};
    end
  end

endmodule

// ----- hw/rtl/fdp_fadd.sv -----
`timescale 1ns / 1ps

module fdp_fadd import fdp_pkg::*; (
  input  logic [FP_W-1:0] x,
  input  logic [FP_W-1:0] y,
  output logic [FP_W-1:0] sum
);

  logic        x_nan, y_nan, x_inf, y_inf, swap, subop;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [23:0] mb, ms;
  logic [26:0] ms_full, ms_al, sn;
  logic        st, g, rs, inc;
  logic [27:0] s;
  logic [4:0]  lz, lim, sh;
  logic [9:0]  er;
  logic [30:0] mag;

  always_comb begin
    x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);

    swap = y[30:0] > x[30:0];
    big  = swap ? y : x;
    sml  = swap ? x : y;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb   = {big[30:23] != 8'd0, big[22:0]};
    ms   = {sml[30:23] != 8'd0, sml[22:0]};
    d    = eb - es;

    // Align the smaller operand with guard, round and sticky bits.
    ms_full = {ms, 3'b000};
    if (d >= 8'd27) begin
      ms_al = 27'd0;
      st    = |ms;
    end else begin
      ms_al = ms_full >> d;
      st    = |(ms_full & ((27'd1 << d) - 27'd1));
    end
    ms_al[0] = ms_al[0] | st;

    subop = big[31] ^ sml[31];
    s = subop ? ({1'b0, mb, 3'b000} - {1'b0, ms_al})
              : ({1'b0, mb, 3'b000} + {1'b0, ms_al});

    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s[i]) lz = 5'(26 - i);
    end
    lim = 5'(eb - 8'd1 > 8'd27 ? 8'd27 : eb - 8'd1);
    sh  = (lz < lim) ? lz : lim;

    if (s[27]) begin
      sn = {s[27:2], s[1] | s[0]};
      er = {2'd0, eb} + 10'd1;
    end else begin
      sn = s[26:0] << sh;
      er = {2'd0, eb} - {5'd0, sh};
      if (!sn[26]) er = 10'd0;
    end

    g   = sn[2];
    rs  = sn[1] | sn[0];
    inc = g & (rs | sn[3]);
    mag = {er[7:0], sn[25:3]} + {30'd0, inc};

    if (x_nan) begin
      sum = x | FP_QUIET_BIT;
    end else if (y_nan) begin
      sum = y | FP_QUIET_BIT;
    end else if (x_inf && y_inf && (x[31] != y[31])) begin
      sum = FP_QNAN_DEFAULT;
    end else if (x_inf) begin
      sum = x;
    end else if (y_inf) begin
      sum = y;
    end else if (s == 28'd0) begin
      // Exact zero: negative only when both operands are negative.
      sum = {big[31] & sml[31], 31'd0};
    end else if (er >= 10'd255) begin
      sum = {big[31], 8'hFF, 23'd0};
    end else begin
      sum = {big[31], mag};
    end
  end

endmodule

// ----- hw/rtl/float_dot_product_8lane.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Payload                                  Transfer when
// operand   in         a_value, b_value (binary32), vector_len  valid && ready
// result    out        dot_value (binary32)                     valid && ready
//
// One element pair is taken every cycle while nothing downstream holds. A
// result passes the input, product and output registers after the last
// element's transfer; if that element closes the full groups of eight, the
// lane sums are first folded in three steps through the adder array while
// execute holds. Reset (rst, synchronous) clears the pipeline, the element
// count, the lane sums and the running total. A stalled result is held in the
// output register while the pipeline keeps accepting items until it fills.

module float_dot_product_8lane import fdp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fdp_in_if.sink    operand,
  fdp_out_if.source result
);

  // Element counter and per-item control decode at the input.
  logic [LEN_W-1:0] idx, n_eff, full_len;
  item_ctl_t        ctl_in;
  logic             acc;

  // Input register stage.
  logic             s0_valid;
  logic [FP_W-1:0]  s0_a, s0_b;
  item_ctl_t        s0_ctl;
  logic             s0_ready;

  // Product register stage.
  logic             s1_valid;
  logic [FP_W-1:0]  s1_prod, mul_out;
  item_ctl_t        s1_ctl;
  logic             s1_ready;

  // Accumulation state.
  logic [FP_W-1:0]  lane_sums [LANES];
  logic [FP_W-1:0]  running_total;
  logic [FP_W-1:0]  p04, p15, p26, p37, q0, q1;
  logic             pend_last;
  red_state_t       rstate, rstate_next;

  // Adder array: lane 0 serves execute and every reduction step.
  logic [FP_W-1:0]  ax [4];
  logic [FP_W-1:0]  ay [4];
  logic [FP_W-1:0]  as_ [4];

  logic             out_valid, out_free;
  logic [FP_W-1:0]  out_data;
  logic             exec_emit, exec_go, fin_go, emit_now;
  logic [FP_W-1:0]  lane_rd, tot_rd;

  always_comb begin
    n_eff    = (operand.vector_length == '0) ? LEN_W'(1) : operand.vector_length;
    full_len = {n_eff[LEN_W-1:LANE_W], LANE_W'(0)};
    ctl_in.zero_k    = (idx == '0);
    ctl_in.in_full   = (idx < full_len);
    ctl_in.first_grp = (idx < LEN_W'(LANES));
    ctl_in.last_full = (full_len != '0) && (idx == full_len - LEN_W'(1));
    ctl_in.last      = (idx >= n_eff - LEN_W'(1));
    ctl_in.lane      = idx[LANE_W-1:0];
  end

  assign acc       = operand.valid && operand.ready;
  assign out_free  = !out_valid || result.ready;
  assign s1_ready  = !s1_valid || exec_go;
  assign s0_ready  = !s0_valid || s1_ready;
  assign operand.ready = s0_ready;

  assign lane_rd   = lane_sums[s1_ctl.lane];
  assign tot_rd    = s1_ctl.zero_k ? FP_POS_ZERO : running_total;
  assign exec_emit = s1_ctl.last && !s1_ctl.last_full;
  assign exec_go   = s1_valid && (rstate == RED_IDLE) && (!exec_emit || out_free);
  assign fin_go    = (rstate == RED_FINAL) && (!pend_last || out_free);
  // A vector ends either straight from execute or at the end of the lane fold.
  assign emit_now  = (exec_go && exec_emit) || (fin_go && pend_last);

  fdp_fmul u_mul (.x(s0_a), .y(s0_b), .prod(mul_out));

  fdp_fadd u_add0 (.x(ax[0]), .y(ay[0]), .sum(as_[0]));
  fdp_fadd u_add1 (.x(ax[1]), .y(ay[1]), .sum(as_[1]));
  fdp_fadd u_add2 (.x(ax[2]), .y(ay[2]), .sum(as_[2]));
  fdp_fadd u_add3 (.x(ax[3]), .y(ay[3]), .sum(as_[3]));

  // Operand order in this selection matters for which NaN propagates.
  always_comb begin
    ax[1] = lane_sums[5];
    ay[1] = lane_sums[1];
    ax[2] = lane_sums[6];
    ay[2] = lane_sums[2];
    ax[3] = lane_sums[7];
    ay[3] = lane_sums[3];
    case (rstate)
      RED_PAIR: begin
        ax[0] = lane_sums[4];
        ay[0] = lane_sums[0];
      end
      RED_QUAD: begin
        ax[0] = p04;
        ay[0] = p26;
        ax[1] = p15;
        ay[1] = p37;
      end
      RED_FINAL: begin
        ax[0] = q0;
        ay[0] = q1;
      end
      default: begin
        if (s1_ctl.in_full) begin
          ax[0] = s1_prod;
          ay[0] = lane_rd;
        end else begin
          ax[0] = tot_rd;
          ay[0] = s1_prod;
        end
      end
    endcase
  end

  // Reduction sequencer.
  always_comb begin
    rstate_next = rstate;
    case (rstate)
      RED_IDLE:  if (exec_go && s1_ctl.last_full) rstate_next = RED_PAIR;
      RED_PAIR:  rstate_next = RED_QUAD;
      RED_QUAD:  rstate_next = RED_FINAL;
      RED_FINAL: if (fin_go) rstate_next = RED_IDLE;
      default:   rstate_next = RED_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate <= RED_IDLE;
    end else begin
      rstate <= rstate_next;
    end
  end

  // Pipeline control and the element counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      idx      <= '0;
    end else begin
      if (s0_ready) s0_valid <= operand.valid;
      if (s1_ready) s1_valid <= s0_valid;
      if (acc) idx <= ctl_in.last ? '0 : idx + LEN_W'(1);
    end
  end

  // Stage payloads need no reset.
  always_ff @(posedge clk) begin
    if (acc) begin
      s0_a   <= operand.a_value;
      s0_b   <= operand.b_value;
      s0_ctl <= ctl_in;
    end
    if (s1_ready && s0_valid) begin
      s1_prod <= mul_out;
      s1_ctl  <= s0_ctl;
    end
    if (rstate == RED_PAIR) begin
      p04 <= as_[0];
      p15 <= as_[1];
      p26 <= as_[2];
      p37 <= as_[3];
    end
    if (rstate == RED_QUAD) begin
      q0 <= as_[0];
      q1 <= as_[1];
    end
  end

  // Lane sums, running total and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) lane_sums[i] <= FP_POS_ZERO;
      running_total <= FP_POS_ZERO;
      pend_last     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
        out_data  <= (exec_go && s1_ctl.in_full) ? tot_rd : as_[0];
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      // The end of a vector returns every lane to positive zero.
      if (emit_now) begin
        for (int i = 0; i < LANES; i++) lane_sums[i] <= FP_POS_ZERO;
      end else if (exec_go && s1_ctl.in_full) begin
        lane_sums[s1_ctl.lane] <= s1_ctl.first_grp ? s1_prod : as_[0];
      end

      if (fin_go) begin
        running_total <= as_[0];
      end else if (exec_go) begin
        if (s1_ctl.in_full) begin
          if (s1_ctl.zero_k) running_total <= FP_POS_ZERO;
          if (s1_ctl.last_full) pend_last <= s1_ctl.last;
        end else begin
          running_total <= as_[0];
        end
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.dot_value = out_data;

endmodule
